// File: rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers for the complex arithmetic unit
// Opcodes, controller-to-datapath command and status, saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int MAX_EXPONENT_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_POW = 2'd3
  } opcode_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ADD,
    CMD_MUL,
    CMD_SUM,
    CMD_RND,
    CMD_DSTART,
    CMD_DWB,
    CMD_DZ,
    CMD_OUT
  } cmd_op_t;

  // which product pair feeds the accumulator adder
  typedef enum logic [2:0] {
    SEL_MUL_RE,
    SEL_MUL_IM,
    SEL_DIV_RE,
    SEL_DIV_IM,
    SEL_DENOM
  } sum_sel_t;

  typedef struct packed {
    cmd_op_t  op;
    logic [2:0] idx;       // product slot for CMD_MUL
    sum_sel_t sel;         // sum select for CMD_SUM
    logic     im;          // write imaginary part on RND/DWB
    logic     init_one;    // LOAD: accumulator starts at 1.0
    logic     use_a;       // LOAD: second operand taken from a
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic d_zero;
  } status_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // clamp a sign/magnitude value to 32-bit two's complement
  function automatic sat_t sat32(logic neg, logic big, logic [64:0] mag);
    sat_t s;
    s.ovf = 1'b1;
    if (!neg && (big || mag > 65'h0_7FFF_FFFF)) begin
      s.val = 32'h7FFF_FFFF;
    end else if (neg && (big || mag > 65'h0_8000_0000)) begin
      s.val = 32'h8000_0000;
    end else begin
      s.ovf = 1'b0;
      s.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end
    return s;
  endfunction

endpackage

// File: rtl/core/complex_arithmetic_unit.sv
// One request at a time: busy stays high until the result strobe; the bit-serial
// divider (one quotient bit per cycle) and the shared 32x32 multiplier set how long
// each request takes. Power on a Q16.16 base: exponent 0 gives 1.0, exponent 1 the
// base, others repeat a multiply, or a divide for a negative exponent, per step.
// A new request may start in the cycle the result strobe is shown; results cannot stall.
// Reset: synchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: Q16.16 complex add, multiply, divide and power
// Sequencer plus datapath; one saturated result per request.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int MAX_EXPONENT  = cau_pkg::MAX_EXPONENT_DEF,
  parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  input  logic signed [5:0]  in_exponent,
  output logic               out_valid,
  output logic signed [31:0] out_result_real,
  output logic signed [31:0] out_result_imag,
  output logic               out_divide_by_zero,
  output logic               out_overflow
);

  cau_pkg::cmd_t    cmd;
  cau_pkg::status_t status;

  cau_ctrl #(
    .MAX_EXPONENT (MAX_EXPONENT),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .opcode   (in_opcode),
    .exponent (in_exponent),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  cau_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_a_real         (in_a_real),
    .in_a_imag         (in_a_imag),
    .in_b_real         (in_b_real),
    .in_b_imag         (in_b_imag),
    .out_result_real   (out_result_real),
    .out_result_imag   (out_result_imag),
    .out_divide_by_zero(out_divide_by_zero),
    .out_overflow      (out_overflow)
  );

endmodule

// File: rtl/core/cau_ctrl.sv
// ----------------------------------------------------------------------------
// cau_ctrl: sequencer for the complex arithmetic unit
// Walks each request through add, product, sum, round and divide steps.
// ----------------------------------------------------------------------------
module cau_ctrl #(
  parameter int MAX_EXPONENT = cau_pkg::MAX_EXPONENT_DEF,
  parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  logic signed [5:0] exponent,
  input  cau_pkg::status_t  status,
  output cau_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              out_valid
);

  localparam int CW = $clog2(MAX_EXPONENT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_MULP, S_SUMD, S_CHKZ, S_SUMRE, S_RNDRE, S_DSTRE, S_DWRE,
    S_SUMIM, S_RNDIM, S_DSTIM, S_DWIM, S_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_r, div_nxt;
  logic          valid_r, valid_nxt;

  logic [6:0]    emag;
  logic [CW-1:0] eclamp;
  logic          last_iter;

  // clamp exponent magnitude
  always_comb begin
    emag = exponent[5] ? (7'd0 - {exponent[5], exponent}) : {1'b0, exponent};
    if (32'(emag) > MAX_EXPONENT) eclamp = CW'(MAX_EXPONENT);
    else eclamp = CW'(emag);
  end

  assign last_iter = (cnt_r == CW'(1));

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    div_nxt      = div_r;
    valid_nxt    = 1'b0;
    cmd          = '0;
    cmd.op       = cau_pkg::CMD_NOP;
    cmd.sel      = cau_pkg::SEL_MUL_RE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op       = cau_pkg::CMD_LOAD;
          cmd.use_a    = (opcode == cau_pkg::OP_POW);
          cmd.init_one = (opcode == cau_pkg::OP_POW) && (exponent <= 6'sd0);
          k_nxt        = 3'd0;
          cnt_nxt      = CW'(1);
          div_nxt      = (opcode == cau_pkg::OP_DIV);
          unique case (opcode)
            cau_pkg::OP_ADD: state_nxt = S_ADD;
            cau_pkg::OP_MUL,
            cau_pkg::OP_DIV: state_nxt = S_MULP;
            default: begin
              if (exponent == 6'sd0) begin
                state_nxt = S_FIN;
              end else if (exponent > 6'sd0) begin
                div_nxt   = 1'b0;
                cnt_nxt   = eclamp - CW'(1);
                state_nxt = (eclamp == CW'(1)) ? S_FIN : S_MULP;
              end else begin
                div_nxt   = 1'b1;
                cnt_nxt   = eclamp;
                state_nxt = S_MULP;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        cmd.op    = cau_pkg::CMD_ADD;
        state_nxt = S_FIN;
      end
      // one product per cycle through the shared multiplier
      S_MULP: begin
        cmd.op  = cau_pkg::CMD_MUL;
        cmd.idx = k_r;
        k_nxt   = k_r + 3'd1;
        if (k_r == (div_r ? 3'd5 : 3'd3)) begin
          k_nxt     = 3'd0;
          state_nxt = div_r ? S_SUMD : S_SUMRE;
        end
      end
      S_SUMD: begin
        cmd.op    = cau_pkg::CMD_SUM;
        cmd.sel   = cau_pkg::SEL_DENOM;
        state_nxt = S_CHKZ;
      end
      S_CHKZ: begin
        if (status.d_zero) begin
          cmd.op    = cau_pkg::CMD_DZ;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SUMRE;
        end
      end
      S_SUMRE: begin
        cmd.op    = cau_pkg::CMD_SUM;
        cmd.sel   = div_r ? cau_pkg::SEL_DIV_RE : cau_pkg::SEL_MUL_RE;
        state_nxt = div_r ? S_DSTRE : S_RNDRE;
      end
      S_RNDRE: begin
        cmd.op    = cau_pkg::CMD_RND;
        state_nxt = S_SUMIM;
      end
      S_DSTRE: begin
        cmd.op    = cau_pkg::CMD_DSTART;
        state_nxt = S_DWRE;
      end
      S_DWRE: begin
        if (status.div_done) begin
          cmd.op    = cau_pkg::CMD_DWB;
          state_nxt = S_SUMIM;
        end
      end
      S_SUMIM: begin
        cmd.op    = cau_pkg::CMD_SUM;
        cmd.sel   = div_r ? cau_pkg::SEL_DIV_IM : cau_pkg::SEL_MUL_IM;
        state_nxt = div_r ? S_DSTIM : S_RNDIM;
      end
      S_RNDIM: begin
        cmd.op    = cau_pkg::CMD_RND;
        cmd.im    = 1'b1;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = last_iter ? S_FIN : S_MULP;
      end
      S_DSTIM: begin
        cmd.op    = cau_pkg::CMD_DSTART;
        state_nxt = S_DWIM;
      end
      S_DWIM: begin
        if (status.div_done) begin
          cmd.op    = cau_pkg::CMD_DWB;
          cmd.im    = 1'b1;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = last_iter ? S_FIN : S_MULP;
        end
      end
      S_FIN: begin
        cmd.op    = cau_pkg::CMD_OUT;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
      div_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      div_r   <= div_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// File: rtl/core/cau_dp.sv
// ----------------------------------------------------------------------------
// cau_dp: datapath for the complex arithmetic unit
// Shared 32x32 multiplier, exact sum and round, bit-serial restoring divider.
// ----------------------------------------------------------------------------
module cau_dp #(
  parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cau_pkg::cmd_t      cmd,
  output cau_pkg::status_t   status,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic signed [31:0] out_result_real,
  output logic signed [31:0] out_result_imag,
  output logic               out_divide_by_zero,
  output logic               out_overflow
);

  localparam int DIV_STEPS = 64 + FRACTION_BITS;
  localparam int DCW       = $clog2(DIV_STEPS);
  localparam logic [64:0] HALF = 65'd1 << (FRACTION_BITS - 1);
  localparam logic [31:0] ONE  = 32'd1 << FRACTION_BITS;

  logic signed [31:0] xre_r, xim_r, yre_r, yim_r;
  logic signed [63:0] p_r [6];
  logic               neg_r;
  logic [63:0]        mag_r, d_r, n_r, rem_r;
  logic [32:0]        q_r;
  logic               big_r, run_r;
  logic [DCW-1:0]     dcnt_r;
  logic               ovf_r, dz_r;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [64:0] sum_c;
  logic signed [32:0] add_re, add_im;
  logic [64:0]        rnd_c, r2;
  logic               ge;
  logic [33:0]        qf;
  cau_pkg::sat_t      s_rnd, s_div, s_are, s_aim;

  // multiplier operand pairs
  always_comb begin
    case (cmd.idx)
      3'd0:    begin ma = xre_r; mb = yre_r; end
      3'd1:    begin ma = xim_r; mb = yim_r; end
      3'd2:    begin ma = xre_r; mb = yim_r; end
      3'd3:    begin ma = xim_r; mb = yre_r; end
      3'd4:    begin ma = yre_r; mb = yre_r; end
      default: begin ma = yim_r; mb = yim_r; end
    endcase
    prod = ma * mb;
  end

  // exact two-product sum
  always_comb begin
    case (cmd.sel)
      cau_pkg::SEL_MUL_RE: sum_c = 65'(p_r[0]) - 65'(p_r[1]);
      cau_pkg::SEL_MUL_IM: sum_c = 65'(p_r[2]) + 65'(p_r[3]);
      cau_pkg::SEL_DIV_RE: sum_c = 65'(p_r[0]) + 65'(p_r[1]);
      cau_pkg::SEL_DIV_IM: sum_c = 65'(p_r[3]) - 65'(p_r[2]);
      default:             sum_c = 65'(p_r[4]) + 65'(p_r[5]);
    endcase
  end

  // rounding, divider step, write-back, add (operands held since load)
  always_comb begin
    rnd_c = ({1'b0, mag_r} + HALF) >> FRACTION_BITS;
    s_rnd = cau_pkg::sat32(neg_r, 1'b0, rnd_c);
    r2    = {rem_r, n_r[63]};
    ge    = (r2 >= {1'b0, d_r});
    qf    = (!big_r && (rem_r >= d_r - rem_r)) ? ({1'b0, q_r} + 34'd1) : {1'b0, q_r};
    s_div = cau_pkg::sat32(neg_r, big_r, 65'(qf));
    add_re = 33'(xre_r) + 33'(yre_r);
    add_im = 33'(xim_r) + 33'(yim_r);
    s_are = cau_pkg::sat32(add_re[32], 1'b0, add_re[32] ? 65'(-add_re) : 65'(add_re));
    s_aim = cau_pkg::sat32(add_im[32], 1'b0, add_im[32] ? 65'(-add_im) : 65'(add_im));
  end

  // divider control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      dcnt_r <= '0;
    end else if (cmd.op == cau_pkg::CMD_DSTART) begin
      run_r  <= 1'b1;
      dcnt_r <= '0;
    end else if (run_r) begin
      dcnt_r <= dcnt_r + DCW'(1);
      if (dcnt_r == DCW'(DIV_STEPS - 1)) run_r <= 1'b0;
    end
  end

  // flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
      dz_r  <= 1'b0;
    end else begin
      case (cmd.op)
        cau_pkg::CMD_LOAD: begin ovf_r <= 1'b0; dz_r <= 1'b0; end
        cau_pkg::CMD_ADD:  ovf_r <= ovf_r | s_are.ovf | s_aim.ovf;
        cau_pkg::CMD_RND:  ovf_r <= ovf_r | s_rnd.ovf;
        cau_pkg::CMD_DWB:  ovf_r <= ovf_r | s_div.ovf;
        cau_pkg::CMD_DZ:   dz_r  <= 1'b1;
        default: ;
      endcase
    end
  end

  // operand, product and quotient registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      cau_pkg::CMD_LOAD: begin
        xre_r <= cmd.init_one ? $signed(ONE) : in_a_real;
        xim_r <= cmd.init_one ? 32'sd0 : in_a_imag;
        yre_r <= cmd.use_a ? in_a_real : in_b_real;
        yim_r <= cmd.use_a ? in_a_imag : in_b_imag;
      end
      cau_pkg::CMD_ADD: begin
        xre_r <= s_are.val;
        xim_r <= s_aim.val;
      end
      cau_pkg::CMD_MUL: p_r[cmd.idx] <= prod;
      cau_pkg::CMD_SUM: begin
        if (cmd.sel == cau_pkg::SEL_DENOM) begin
          d_r <= sum_c[63:0];
        end else begin
          neg_r <= sum_c[64];
          mag_r <= sum_c[64] ? 64'(-sum_c) : sum_c[63:0];
        end
      end
      cau_pkg::CMD_RND: begin
        if (cmd.im) xim_r <= s_rnd.val;
        else xre_r <= s_rnd.val;
      end
      cau_pkg::CMD_DSTART: begin
        n_r   <= mag_r;
        rem_r <= '0;
        q_r   <= '0;
        big_r <= 1'b0;
      end
      cau_pkg::CMD_DWB: begin
        if (cmd.im) xim_r <= s_div.val;
        else xre_r <= s_div.val;
      end
      cau_pkg::CMD_OUT: begin
        out_result_real <= dz_r ? 32'sd0 : xre_r;
        out_result_imag <= dz_r ? 32'sd0 : xim_r;
        out_divide_by_zero <= dz_r;
        out_overflow <= ovf_r;
      end
      default: ;
    endcase
    // one quotient bit per cycle
    if (run_r) begin
      n_r   <= n_r << 1;
      rem_r <= ge ? 64'(r2 - {1'b0, d_r}) : r2[63:0];
      if (!big_r) begin
        if (q_r[32]) big_r <= 1'b1;
        else q_r <= {q_r[31:0], ge};
      end
    end
  end

  assign status.div_done = !run_r;
  assign status.d_zero   = (d_r == 64'd0);

endmodule

// File: rtl/core/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for the complex arithmetic unit
// Request/result sequencing and divide-by-zero result forcing.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_result_real,
  input logic signed [31:0] out_result_imag,
  input logic               out_divide_by_zero
);

  // accepted request keeps the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after request");

  // strobe lasts a single cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // finishing a request shows its result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without a result");

  // a result only follows a busy cycle
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a request");

  // zero divisor forces a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_real == 0 && out_result_imag == 0)
    else $error("divide by zero result not zero");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// File: test/complex_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_test: self-checking bench for the complex unit
// Directed corner requests from a table, then bursts of random requests with
// random gaps. Every result is checked field by field against a typed answer or a built-in
// Q16.16 predictor of add, multiply, divide and power.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_test;

  localparam int FRAC       = cau_pkg::FRACTION_BITS_DEF;
  localparam int MAX_EXP    = cau_pkg::MAX_EXPONENT_DEF;
  localparam int N_RANDOM   = 950;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_DIRECTED = 24;

  typedef struct {
    cau_pkg::opcode_t   op;
    logic signed [31:0] ar, ai, br, bi;
    logic signed [5:0]  e;
  } request_t;

  typedef struct {
    logic signed [31:0] re, im;
    logic               dz, ovf;
  } answer_t;

  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } plan_row_t;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_opcode = '0;
  logic signed [31:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic signed [5:0]  in_exponent = '0;
  logic               out_valid;
  logic signed [31:0] out_result_real, out_result_imag;
  logic               out_divide_by_zero, out_overflow;

  answer_t   pending_answers[$];
  plan_row_t plan [N_DIRECTED];
  int        error_count = 0;
  int        checked = 0;
  int        idle_cycles = 0;
  int        op_count [4] = '{0, 0, 0, 0};
  int        dz_seen = 0, ovf_seen = 0;

  always #1 clk = ~clk;

  complex_arithmetic_unit u_top (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_a_real, .in_a_imag, .in_b_real,
    .in_b_imag, .in_exponent, .out_valid, .out_result_real, .out_result_imag,
    .out_divide_by_zero, .out_overflow
  );

  // ---------------------------------------------------------------- predictor
  // exact two-term sum as sign and magnitude
  function automatic void split_sum(longint p1, longint p2, output bit neg,
                                    output bit [63:0] mag);
    bit [63:0] s;
    s = p1 + p2;
    neg = s[63];
    if (s == 64'h8000_0000_0000_0000 && p1 > 0) neg = 1'b0;
    mag = neg ? (64'd0 - s) : s;
  endfunction

  function automatic longint clamp32(bit neg, bit big, bit [63:0] mag, inout bit ovf);
    if (!neg && (big || mag > 64'h7FFF_FFFF)) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (neg && (big || mag > 64'h8000_0000)) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint rounded_sum(longint p1, longint p2, inout bit ovf);
    bit        neg;
    bit [63:0] mag;
    split_sum(p1, p2, neg, mag);
    mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
    return clamp32(neg, 1'b0, mag, ovf);
  endfunction

  function automatic cplx_t cplx_mul(cplx_t x, cplx_t y, inout bit ovf);
    cplx_t r;
    r.re = rounded_sum(x.re * y.re, -(x.im * y.im), ovf);
    r.im = rounded_sum(x.re * y.im, x.im * y.re, ovf);
    return r;
  endfunction

  // rounded n * 2^FRAC / d, bit-serial; big when the quotient passes 32 bits
  function automatic bit [63:0] scaled_quotient(bit [63:0] n, bit [63:0] d, output bit big);
    bit [63:0] r, q;
    bit        nb, qb;
    r = '0;
    q = '0;
    big = 1'b0;
    for (int i = 0; i < 64 + FRAC; i++) begin
      nb = (i < 64) ? n[63 - i] : 1'b0;
      qb = 1'b0;
      r = {r[62:0], nb};
      if (r >= d) begin
        r = r - d;
        qb = 1'b1;
      end
      if (!big) begin
        if (q[63:32] != 0) big = 1'b1;
        else q = {q[62:0], qb};
      end
    end
    if (!big && r >= d - r) q = q + 1;
    return q;
  endfunction

  function automatic longint quotient_part(longint p1, longint p2, bit [63:0] d,
                                           inout bit ovf);
    bit        neg, big;
    bit [63:0] mag, q;
    split_sum(p1, p2, neg, mag);
    q = scaled_quotient(mag, d, big);
    return clamp32(neg, big, q, ovf);
  endfunction

  function automatic cplx_t cplx_div(cplx_t x, cplx_t y, inout bit ovf, inout bit dz);
    cplx_t     r;
    bit [63:0] d;
    d = 64'(y.re * y.re) + 64'(y.im * y.im);
    if (d == 0) begin
      dz = 1'b1;
      r.re = 0;
      r.im = 0;
      return r;
    end
    r.re = quotient_part(x.re * y.re, x.im * y.im, d, ovf);
    r.im = quotient_part(x.im * y.re, -(x.re * y.im), d, ovf);
    return r;
  endfunction

  function automatic longint clamp_add(longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic answer_t predict_answer(request_t q);
    cplx_t   a, b, r;
    bit      ovf, dz;
    int      e;
    answer_t ans;
    ovf = 1'b0;
    dz = 1'b0;
    a.re = q.ar;
    a.im = q.ai;
    b.re = q.br;
    b.im = q.bi;
    e = q.e;
    case (q.op)
      cau_pkg::OP_ADD: begin
        r.re = clamp_add(a.re + b.re, ovf);
        r.im = clamp_add(a.im + b.im, ovf);
      end
      cau_pkg::OP_MUL: r = cplx_mul(a, b, ovf);
      cau_pkg::OP_DIV: r = cplx_div(a, b, ovf, dz);
      default: begin
        if (e > MAX_EXP) e = MAX_EXP;
        if (e < -MAX_EXP) e = -MAX_EXP;
        r.re = longint'(1) << FRAC;
        r.im = 0;
        if (e > 0) begin
          r = a;
          for (int i = 0; i < e - 1; i++) r = cplx_mul(r, a, ovf);
        end else begin
          for (int i = 0; i < -e; i++) r = cplx_div(r, a, ovf, dz);
        end
      end
    endcase
    if (dz) begin
      r.re = 0;
      r.im = 0;
    end
    ans.re = r.re[31:0];
    ans.im = r.im[31:0];
    ans.dz = dz;
    ans.ovf = ovf;
    return ans;
  endfunction

  // ---------------------------------------------------------------- result check
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, out_result_real,
                 out_result_imag);
        error_count++;
      end else begin
        answer_t w;
        w = pending_answers.pop_front();
        checked++;
        if (out_result_real !== w.re) begin
          $display("%0t: result_real expected %h actual %h", $time, w.re, out_result_real);
          error_count++;
        end
        if (out_result_imag !== w.im) begin
          $display("%0t: result_imag expected %h actual %h", $time, w.im, out_result_imag);
          error_count++;
        end
        if (out_divide_by_zero !== w.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, w.dz,
                   out_divide_by_zero);
          error_count++;
        end
        if (out_overflow !== w.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, w.ovf, out_overflow);
          error_count++;
        end
        dz_seen += w.dz;
        ovf_seen += w.ovf;
      end
    end
  end

  // watchdog: cycles with neither a request nor a result accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  int burst_left = 0;

  // present one request at the falling edge and hold it until it is accepted
  task automatic issue_request(request_t q, bit typed, answer_t typed_ans);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start = 1'b1;
    in_opcode = q.op;
    in_a_real = q.ar;
    in_a_imag = q.ai;
    in_b_real = q.br;
    in_b_imag = q.bi;
    in_exponent = q.e;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_answers.push_back(typed ? typed_ans : predict_answer(q));
    op_count[q.op]++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_part();
    case ($urandom_range(0, 9))
      0: return 32'sh0;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic request_t random_request();
    request_t q;
    q.op = cau_pkg::opcode_t'($urandom_range(0, 3));
    q.ar = random_part();
    q.ai = random_part();
    q.br = random_part();
    q.bi = random_part();
    if ($urandom_range(0, 19) == 0) q.e = 6'($urandom);
    else q.e = 6'($signed($urandom_range(0, 8)) - 4);
    // power of a small-magnitude base keeps results away from saturation
    if (q.op == cau_pkg::OP_POW && $urandom_range(0, 1)) begin
      q.ar = $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
      q.ai = $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
    end
    return q;
  endfunction

  initial begin
    request_t q;
    answer_t  none;
    none = '{re: 0, im: 0, dz: 0, ovf: 0};
    // corner requests; rows with typed answers carry them, the rest use the predictor
    plan = '{
      '{'{cau_pkg::OP_ADD, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
      '{'{cau_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1, 0}, 1,
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1}},
      '{'{cau_pkg::OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          0}, 1, '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1}},
      '{'{cau_pkg::OP_DIV, 32'sh0001_0000, 0, 0, 0, 0}, 1, '{0, 0, 1, 0}},
      '{'{cau_pkg::OP_DIV, 0, 0, 32'sh0001_0000, 0, 0}, 1, '{0, 0, 0, 0}},
      '{'{cau_pkg::OP_POW, 32'sh1234_5678, -77, 0, 0, 0}, 1, '{32'sh0001_0000, 0, 0, 0}},
      '{'{cau_pkg::OP_POW, 0, 0, 9, 9, -3}, 1, '{0, 0, 1, 0}},
      '{'{cau_pkg::OP_POW, 5, -7, 0, 0, 1}, 1, '{5, -7, 0, 0}},
      '{'{cau_pkg::OP_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0}, 1, '{0, 0, 0, 0}},
      '{'{cau_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          0}, 0, none},
      '{'{cau_pkg::OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
          0}, 0, none},
      '{'{cau_pkg::OP_MUL, 32'sh0002_8000, -32'sh0001_4000, 32'sh0000_0001, 32'sh0000_8000,
          0}, 0, none},
      '{'{cau_pkg::OP_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, 0}, 0, none},
      '{'{cau_pkg::OP_DIV, 32'sh7FFF_FFFF, 1, 32'sh8000_0000, 32'sh8000_0000, 0}, 0, none},
      '{'{cau_pkg::OP_DIV, 32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000,
          0}, 0, none},
      '{'{cau_pkg::OP_DIV, 32'sh0001_0000, 0, 32'sh0003_0000, 0, 0}, 0, none},
      '{'{cau_pkg::OP_POW, 32'sh0001_0000, 0, 0, 0, 31}, 0, none},
      '{'{cau_pkg::OP_POW, 32'sh0002_0000, 0, 0, 0, -32}, 0, none},
      '{'{cau_pkg::OP_POW, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 16}, 0, none},
      '{'{cau_pkg::OP_POW, 32'sh0000_8000, 32'sh0000_8000, 0, 0, -16}, 0, none},
      '{'{cau_pkg::OP_POW, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 2}, 0, none},
      '{'{cau_pkg::OP_POW, 32'sh8000_0000, 0, 0, 0, -1}, 0, none},
      '{'{cau_pkg::OP_POW, 32'sh0000_0001, 0, 0, 0, -2}, 0, none},
      '{'{cau_pkg::OP_MUL, -32'sh0000_8000, 32'sh0000_0001, 32'sh0000_0001, -32'sh0000_8000,
          0}, 0, none}
    };

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) issue_request(plan[i].req, plan[i].typed, plan[i].ans);
    for (int n = 0; n < N_RANDOM; n++) begin
      q = random_request();
      issue_request(q, 1'b0, none);
    end
    start = 1'b0;

    // drain; the watchdog bounds this wait
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Covered %0d add, %0d multiply, %0d divide, %0d power requests;",
             op_count[cau_pkg::OP_ADD], op_count[cau_pkg::OP_MUL],
             op_count[cau_pkg::OP_DIV], op_count[cau_pkg::OP_POW]);
    $display("%0d results checked, %0d with divide by zero, %0d with overflow.",
             checked, dz_seen, ovf_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: complex_arithmetic_unit.f
rtl/core/cau_pkg.sv
rtl/core/cau_ctrl.sv
rtl/core/cau_dp.sv
rtl/core/complex_arithmetic_unit.sv
rtl/core/cau_checker.sv
test/complex_arithmetic_unit_test.sv
